[hdl/pqp_pkg.sv]
// ----------------------------------------------------------------------------
// pqp_pkg
// Shared constants for the particle quantum parameter block: default word
// sizes, register codes, reset values and fixed-point scale factors.
// ----------------------------------------------------------------------------
package pqp_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CHARGE_W   = 8;
    localparam int MASS_W     = 32;
    localparam int MASS_FRAC  = 24;
    localparam int SCHW_W     = 48;
    localparam int SCHW_FRAC  = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    // reduced magnitudes at or above this bit flag an overflow
    localparam int OVF_BIT = 62;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCHW    = 2'd1;

    localparam logic [MASS_W-1:0] INV_MASS_SQ_RST = 32'd16777216;
    localparam logic [SCHW_W-1:0] INV_SCHW_RST    = 48'd683000000;

endpackage

[hdl/pqp_if.sv]
// ----------------------------------------------------------------------------
// pqp_in_if / pqp_out_if
// Valid/ready channels for particle requests and quantum parameter results.
// ----------------------------------------------------------------------------
interface pqp_in_if #(
    parameter int W = pqp_pkg::WORD_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [pqp_pkg::CHARGE_W-1:0] charge;
    logic signed [W-1:0]                 mom_x;
    logic signed [W-1:0]                 mom_y;
    logic signed [W-1:0]                 mom_z;
    logic signed [W-1:0]                 efield_x;
    logic signed [W-1:0]                 efield_y;
    logic signed [W-1:0]                 efield_z;
    logic signed [W-1:0]                 bfield_x;
    logic signed [W-1:0]                 bfield_y;
    logic signed [W-1:0]                 bfield_z;

    modport source (
        output valid, charge, mom_x, mom_y, mom_z,
               efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z,
        input  ready
    );
    modport sink (
        input  valid, charge, mom_x, mom_y, mom_z,
               efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z,
        output ready
    );
endinterface

interface pqp_out_if #(
    parameter int W = pqp_pkg::WORD_WIDTH_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] lorentz_factor;
    logic [W-1:0] chi_value;
    logic         saturated;

    modport source (
        output valid, lorentz_factor, chi_value, saturated,
        input  ready
    );
    modport sink (
        input  valid, lorentz_factor, chi_value, saturated,
        output ready
    );
endinterface

[hdl/pqp_mul.sv]
// ----------------------------------------------------------------------------
// pqp_mul
// Two-stage unsigned multiplier: four half-width partial products, then one
// registered sum.
// ----------------------------------------------------------------------------
module pqp_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [PW-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[AL-1:0] * i_b[BL-1:0];
            r_lh <= i_a[AL-1:0] * i_b[BW-1:BL];
            r_hl <= i_a[AW-1:AL] * i_b[BL-1:0];
            r_hh <= i_a[AW-1:AL] * i_b[BW-1:BL];
            r_p  <= PW'(r_ll) + (PW'(r_lh) << BL) + (PW'(r_hl) << AL)
                    + (PW'(r_hh) << (AL + BL));
        end
    end

    assign o_p = r_p;

endmodule

[hdl/pqp_isqrt.sv]
// ----------------------------------------------------------------------------
// pqp_isqrt
// Pipelined floor square root, one root bit per stage, with a sideband that
// travels alongside the radicand.
// ----------------------------------------------------------------------------
module pqp_isqrt #(
    parameter int RW  = 33,
    parameter int SBW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SBW-1:0]  i_side,
    output logic            o_vld,
    output logic [RW-1:0]   o_root,
    output logic [SBW-1:0]  o_side
);

    localparam int MW = RW + 2;

    logic [MW-1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rad  [RW];
    logic [SBW-1:0]  r_side [RW];
    logic [RW-1:0]   r_vld;

    logic [MW-1:0]   n_rem  [RW];
    logic [RW-1:0]   n_root [RW];
    logic [2*RW-1:0] n_rad  [RW];

    always_comb begin
        logic [MW-1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] rad_in;
        logic [MW+1:0]   tmp;
        logic [MW+1:0]   trial;
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = i_rad;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                rad_in  = r_rad[k-1];
            end
            // bring down the next two radicand bits
            tmp   = {rem_in, rad_in[2*RW-1 -: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (tmp >= trial) begin
                n_rem[k]  = MW'(tmp - trial);
                n_root[k] = {root_in[RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = MW'(tmp);
                n_root[k] = {root_in[RW-2:0], 1'b0};
            end
            n_rad[k] = rad_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RW-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                if (k == 0) begin
                    r_side[k] <= i_side;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

[hdl/particle_quantum_parameter.sv]
// ----------------------------------------------------------------------------
// particle_quantum_parameter
// Lorentz factor and quantum parameter chi for a stream of particles.
// ----------------------------------------------------------------------------
// Particle requests arrive on i_in (charge, momentum, E and B at the
// particle); each yields one result on o_out: gamma, chi and a saturation
// flag. Two registers, inverse squared mass and inverse Schwinger field, are
// written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while no request is in flight, which the block does not enforce.
// Throughput is one request per cycle while the output is not stalled. A
// request passes two one-bit-a-stage square root pipelines (gamma, then the
// field invariant), five two-stage multiplier passes, and sum, reduce and
// output stages.
// Reset clears every valid bit and loads the register defaults; payload
// registers are not cleared.
// A stalled result stays in the output register; requests still enter while
// the last pipeline stage is empty, and the pipeline freezes without loss
// once the last stage holds a request and the output cannot take it.
// ----------------------------------------------------------------------------
module particle_quantum_parameter #(
    parameter int WORD_WIDTH = pqp_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = pqp_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pqp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pqp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pqp_in_if.sink                           i_in,
    pqp_out_if.source                        o_out
);

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int GW  = W + 1;
    localparam int SW  = 2 * GW;
    localparam int PW  = 2 * W + 4;
    localparam int AWF = PW - F;
    localparam int AW  = (AWF > pqp_pkg::OVF_BIT) ? pqp_pkg::OVF_BIT : AWF;
    localparam int QW  = AW + 1;
    localparam int DW  = 2 * QW;
    localparam int CW  = pqp_pkg::CHARGE_W;
    localparam int KW  = CW + pqp_pkg::MASS_W;
    localparam int T1W = QW + KW - pqp_pkg::MASS_FRAC;
    localparam int SCW = pqp_pkg::SCHW_W;

    typedef struct packed {
        logic [2:0]        psg;
        logic [2:0]        esg;
        logic [2:0]        bsg;
        logic [2:0][W-1:0] em;
        logic [CW-1:0]     cmag;
    } t_s1;

    typedef struct packed {
        logic [PW-1:0]      a;
        logic [2:0][PW-1:0] c;
        logic [2:0][W-1:0]  em;
        logic [2:0]         esg;
        logic [CW-1:0]      cmag;
    } t_s3;

    typedef struct packed {
        logic [PW-1:0]      a;
        logic [2:0][PW-1:0] c;
        logic [2:0]         esg;
        logic [CW-1:0]      cmag;
        logic [W-1:0]       gam;
        logic               gsat;
    } t_s4;

    typedef struct packed {
        logic [3:0][PW-1:0] red;
        logic [CW-1:0]      cmag;
        logic [W-1:0]       gam;
        logic               gsat;
    } t_s5;

    typedef struct packed {
        logic          ovf;
        logic [CW-1:0] cmag;
        logic [W-1:0]  gam;
        logic          gsat;
    } t_s6;

    function automatic logic [PW-1:0] sgn(input logic [2*W-1:0] mag, input logic neg);
        logic [PW-1:0] m;
        m = PW'(mag);
        return neg ? (~m + 1'b1) : m;
    endfunction

    // configuration registers
    logic [pqp_pkg::MASS_W-1:0] r_inv_mass;
    logic [SCW-1:0]             r_inv_schw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass <= pqp_pkg::INV_MASS_SQ_RST;
            r_inv_schw <= pqp_pkg::INV_SCHW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pqp_pkg::CFG_INV_MASS_SQ: r_inv_mass <= i_cfg_data[pqp_pkg::MASS_W-1:0];
                pqp_pkg::CFG_INV_SCHW:    r_inv_schw <= i_cfg_data[SCW-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    logic r0_vld, r1_vld, r2_vld, r3_vld, r4a_vld, r4b_vld, r5_vld, r6_vld;
    logic r7a_vld, r7b_vld, r8_vld, r9_vld, r10_vld, r11a_vld, r11b_vld;
    logic r12a_vld, r12b_vld, r_out_vld;
    logic w_g_vld, w_s_vld;
    logic w_en;

    // pipeline advances unless the last stage is blocked by a held result
    assign w_en       = !r12b_vld || !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld   <= 1'b0;
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_vld   <= 1'b0;
            r4a_vld  <= 1'b0;
            r4b_vld  <= 1'b0;
            r5_vld   <= 1'b0;
            r6_vld   <= 1'b0;
            r7a_vld  <= 1'b0;
            r7b_vld  <= 1'b0;
            r8_vld   <= 1'b0;
            r9_vld   <= 1'b0;
            r10_vld  <= 1'b0;
            r11a_vld <= 1'b0;
            r11b_vld <= 1'b0;
            r12a_vld <= 1'b0;
            r12b_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld   <= i_in.valid;
            r1_vld   <= r0_vld;
            r2_vld   <= r1_vld;
            r3_vld   <= r2_vld;
            r4a_vld  <= w_g_vld;
            r4b_vld  <= r4a_vld;
            r5_vld   <= r4b_vld;
            r6_vld   <= r5_vld;
            r7a_vld  <= r6_vld;
            r7b_vld  <= r7a_vld;
            r8_vld   <= r7b_vld;
            r9_vld   <= r8_vld;
            r10_vld  <= w_s_vld;
            r11a_vld <= r10_vld;
            r11b_vld <= r11a_vld;
            r12a_vld <= r11b_vld;
            r12b_vld <= r12a_vld;
        end
    end

    // stage 0: sign and magnitude split
    logic [2:0][W-1:0]  w_rp, w_re, w_rb;
    logic [2:0]         r0_psg, r0_esg, r0_bsg;
    logic [2:0][W-1:0]  r0_pm, r0_em, r0_bm;
    logic [CW-1:0]      r0_cmag;

    assign w_rp = {i_in.mom_z, i_in.mom_y, i_in.mom_x};
    assign w_re = {i_in.efield_z, i_in.efield_y, i_in.efield_x};
    assign w_rb = {i_in.bfield_z, i_in.bfield_y, i_in.bfield_x};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r0_psg[i] <= w_rp[i][W-1];
                r0_esg[i] <= w_re[i][W-1];
                r0_bsg[i] <= w_rb[i][W-1];
                r0_pm[i]  <= w_rp[i][W-1] ? (~w_rp[i] + 1'b1) : w_rp[i];
                r0_em[i]  <= w_re[i][W-1] ? (~w_re[i] + 1'b1) : w_re[i];
                r0_bm[i]  <= w_rb[i][W-1] ? (~w_rb[i] + 1'b1) : w_rb[i];
            end
            r0_cmag <= i_in.charge[CW-1] ? (~i_in.charge + 1'b1) : i_in.charge;
        end
    end

    // stages 1-2: momentum squares, E.p terms, cross product terms
    logic [2:0][2*W-1:0] w_pp, w_ep, w_cjl, w_clj;

    for (genvar gi = 0; gi < 3; gi++) begin : g_mul1
        localparam int GJ = (gi == 2) ? 0 : gi + 1;
        localparam int GL = (gi == 0) ? 2 : gi - 1;
        pqp_mul #(.AW(W), .BW(W)) u_pp (
            .i_clk(i_clk), .i_en(w_en), .i_a(r0_pm[gi]), .i_b(r0_pm[gi]), .o_p(w_pp[gi])
        );
        pqp_mul #(.AW(W), .BW(W)) u_ep (
            .i_clk(i_clk), .i_en(w_en), .i_a(r0_em[gi]), .i_b(r0_pm[gi]), .o_p(w_ep[gi])
        );
        pqp_mul #(.AW(W), .BW(W)) u_cjl (
            .i_clk(i_clk), .i_en(w_en), .i_a(r0_pm[GJ]), .i_b(r0_bm[GL]), .o_p(w_cjl[gi])
        );
        pqp_mul #(.AW(W), .BW(W)) u_clj (
            .i_clk(i_clk), .i_en(w_en), .i_a(r0_pm[GL]), .i_b(r0_bm[GJ]), .o_p(w_clj[gi])
        );
    end

    t_s1 w_s0, r1_s, r2_s;

    assign w_s0 = '{psg: r0_psg, esg: r0_esg, bsg: r0_bsg, em: r0_em, cmag: r0_cmag};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_s <= w_s0;
            r2_s <= r1_s;
        end
    end

    // stage 3: |p|^2 + 1, E.p and p x B as signed sums
    logic [SW-1:0] n3_rad, r3_rad;
    t_s3           n3_s, r3_s;

    always_comb begin
        int j;
        int l;
        n3_rad = (SW'(1) << (2 * F)) + SW'(w_pp[0]) + SW'(w_pp[1]) + SW'(w_pp[2]);
        n3_s.a = sgn(w_ep[0], r2_s.esg[0] ^ r2_s.psg[0])
               + sgn(w_ep[1], r2_s.esg[1] ^ r2_s.psg[1])
               + sgn(w_ep[2], r2_s.esg[2] ^ r2_s.psg[2]);
        for (int i = 0; i < 3; i++) begin
            j = (i == 2) ? 0 : i + 1;
            l = (i == 0) ? 2 : i - 1;
            n3_s.c[i] = sgn(w_cjl[i], r2_s.psg[j] ^ r2_s.bsg[l])
                      - sgn(w_clj[i], r2_s.psg[l] ^ r2_s.bsg[j]);
        end
        n3_s.em   = r2_s.em;
        n3_s.esg  = r2_s.esg;
        n3_s.cmag = r2_s.cmag;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rad <= n3_rad;
            r3_s   <= n3_s;
        end
    end

    // gamma square root
    logic [GW-1:0] w_g_root;
    t_s3           w_g_side;

    pqp_isqrt #(.RW(GW), .SBW($bits(t_s3))) u_sqrt_gam (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r3_vld),
        .i_rad  (r3_rad),
        .i_side (r3_s),
        .o_vld  (w_g_vld),
        .o_root (w_g_root),
        .o_side (w_g_side)
    );

    logic         w_gsat;
    logic [W-1:0] w_gam;

    assign w_gsat = w_g_root[W];
    assign w_gam  = w_gsat ? '1 : w_g_root[W-1:0];

    // gamma * E
    logic [2:0][2*W-1:0] w_ge;

    for (genvar gi = 0; gi < 3; gi++) begin : g_mul2
        pqp_mul #(.AW(W), .BW(W)) u_ge (
            .i_clk(i_clk), .i_en(w_en), .i_a(w_gam), .i_b(w_g_side.em[gi]), .o_p(w_ge[gi])
        );
    end

    t_s4 w_s4, r4a_s, r4b_s;

    assign w_s4 = '{a: w_g_side.a, c: w_g_side.c, esg: w_g_side.esg,
                    cmag: w_g_side.cmag, gam: w_gam, gsat: w_gsat};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4a_s <= w_s4;
            r4b_s <= r4a_s;
        end
    end

    // stage 5: gamma*E + p x B
    t_s5 n5_s, r5_s;

    always_comb begin
        n5_s.red[0] = r4b_s.a;
        for (int i = 0; i < 3; i++) begin
            n5_s.red[i+1] = sgn(w_ge[i], r4b_s.esg[i]) + r4b_s.c[i];
        end
        n5_s.cmag = r4b_s.cmag;
        n5_s.gam  = r4b_s.gam;
        n5_s.gsat = r4b_s.gsat;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_s <= n5_s;
        end
    end

    // stage 6: magnitudes back to Q.F, toward zero
    logic [3:0][AW-1:0] n6_mag, r6_mag;
    logic               n6_ovf;
    t_s6                r6_s;

    always_comb begin
        logic [PW-1:0] mag;
        logic [PW-1:0] sh;
        n6_ovf = 1'b0;
        for (int i = 0; i < 4; i++) begin
            mag       = r5_s.red[i][PW-1] ? (~r5_s.red[i] + 1'b1) : r5_s.red[i];
            sh        = mag >> F;
            n6_ovf    = n6_ovf | ((sh >> pqp_pkg::OVF_BIT) != '0);
            n6_mag[i] = sh[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_mag <= n6_mag;
            r6_s   <= '{ovf: n6_ovf, cmag: r5_s.cmag, gam: r5_s.gam, gsat: r5_s.gsat};
        end
    end

    // squares of a and of the three components
    logic [3:0][2*AW-1:0] w_sq;

    for (genvar gi = 0; gi < 4; gi++) begin : g_mul3
        pqp_mul #(.AW(AW), .BW(AW)) u_sq (
            .i_clk(i_clk), .i_en(w_en), .i_a(r6_mag[gi]), .i_b(r6_mag[gi]), .o_p(w_sq[gi])
        );
    end

    t_s6 r7a_s, r7b_s, r8_s, r9_s;

    logic [2*AW-1:0] r8_a2;
    logic [DW-1:0]   r8_vs;
    logic [DW-1:0]   r9_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7a_s <= r6_s;
            r7b_s <= r7a_s;
            r8_a2 <= w_sq[0];
            r8_vs <= DW'(w_sq[1]) + DW'(w_sq[2]) + DW'(w_sq[3]);
            r8_s  <= r7b_s;
            r9_d  <= (DW'(r8_a2) < r8_vs) ? (r8_vs - DW'(r8_a2)) : (DW'(r8_a2) - r8_vs);
            r9_s  <= r8_s;
        end
    end

    // invariant square root
    logic [QW-1:0] w_s_root;
    t_s6           w_s_side;

    pqp_isqrt #(.RW(QW), .SBW($bits(t_s6))) u_sqrt_inv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r9_vld),
        .i_rad  (r9_d),
        .i_side (r9_s),
        .o_vld  (w_s_vld),
        .o_root (w_s_root),
        .o_side (w_s_side)
    );

    // scale by |q| * inv_mass_sq, then by inv_schwinger_field
    logic [QW-1:0]  r10_sq;
    logic [KW-1:0]  r10_k;
    t_s6            r10_s, r11a_s, r11b_s, r12a_s, r12b_s;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_sq <= w_s_root;
            r10_k  <= KW'(w_s_side.cmag) * KW'(r_inv_mass);
            r10_s  <= w_s_side;
            r11a_s <= r10_s;
            r11b_s <= r11a_s;
            r12a_s <= r11b_s;
            r12b_s <= r12a_s;
        end
    end

    logic [QW+KW-1:0]  w_sk;
    logic [T1W-1:0]    w_t1;
    logic [T1W+SCW-1:0] w_ts;
    logic [T1W-1:0]    w_t2;

    pqp_mul #(.AW(QW), .BW(KW)) u_mul_k (
        .i_clk(i_clk), .i_en(w_en), .i_a(r10_sq), .i_b(r10_k), .o_p(w_sk)
    );

    assign w_t1 = w_sk[QW+KW-1:pqp_pkg::MASS_FRAC];

    pqp_mul #(.AW(T1W), .BW(SCW)) u_mul_schw (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_t1), .i_b(r_inv_schw), .o_p(w_ts)
    );

    assign w_t2 = w_ts[T1W+SCW-1:pqp_pkg::SCHW_FRAC];

    logic         w_csat;
    logic [W-1:0] w_chi;

    assign w_csat = r12b_s.ovf || (w_t2[T1W-1:W] != '0);
    assign w_chi  = w_csat ? '1 : w_t2[W-1:0];

    // output register
    logic [W-1:0] r_out_gam, r_out_chi;
    logic         r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && r12b_vld) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r12b_vld) begin
            r_out_gam <= r12b_s.gam;
            r_out_chi <= w_chi;
            r_out_sat <= r12b_s.gsat | w_csat;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.lorentz_factor = r_out_gam;
    assign o_out.chi_value      = r_out_chi;
    assign o_out.saturated      = r_out_sat;

endmodule

[hdl/pqp_checker.sv]
// ----------------------------------------------------------------------------
// pqp_checker
// Port-level checks for the particle quantum parameter block.
// ----------------------------------------------------------------------------
module pqp_checker #(
    parameter int W = pqp_pkg::WORD_WIDTH_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_out_gam,
    input logic [W-1:0] i_out_chi,
    input logic         i_out_sat
);

    logic [7:0] r_pend;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {7'd0, w_in_acc} - {7'd0, w_out_acc};
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_gam) && $stable(i_out_chi) && $stable(i_out_sat)))
        else $error("stalled result changed or dropped");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_pend != '0))
        else $error("result delivered without a pending request");

endmodule

bind particle_quantum_parameter pqp_checker #(.W(WORD_WIDTH)) u_pqp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_gam  (o_out.lorentz_factor),
    .i_out_chi  (o_out.chi_value),
    .i_out_sat  (o_out.saturated)
);
